// ----- design/spq_pkg.sv -----
package spq_pkg;

  typedef struct packed {
    logic [15:0] prio;
    logic [15:0] tag;
  } entry_t;

  // shift command from the top level to every cell
  typedef struct packed {
    logic ins;
    logic srv;
  } ctrl_t;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SERVE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_SERVED   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

endpackage

// ----- design/spq_cell.sv -----
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk_i,
  input  ctrl_t  ctrl_i,
  input  logic   occupied_i,
  input  entry_t new_i,
  input  logic   left_keep_i,
  input  entry_t left_i,
  input  entry_t right_i,
  output logic   keep_o,
  output entry_t entry_o
);

  entry_t entry_q, entry_d;

  // held entry stays in place on insert when it ranks at or above the new one
  assign keep_o = occupied_i && (entry_q.prio >= new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? new_i : left_i;
      end
    end else if (ctrl_i.srv) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- design/stable_priority_queue.sv -----
// Channel  Dir  tuser         tdata (low bit first)
// s_axis   in   opcode[1:0]   entry_priority[15:0], entry_tag[31:16]
// m_axis   out  status[2:0]   served_tag[15:0], served_priority[31:16], queue_count[38:32]
//
// One item per cycle while m_axis is not stalled: every cell of the sorted chain
// compares against the new entry at once and shifts by one place in the same edge.
// Result comes from an output register, valid in the cycle after acceptance.
// Input is taken while the output register is empty or being drained.
// Reset clears the count and the output valid; cell contents are not reset.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // entry_priority, entry_tag
  input  logic [1:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // served_tag, served_priority, queue_count
  output logic [2:0]  m_axis_tuser    // status
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [1:0]  op;
  entry_t      new_entry;
  logic        in_acc;
  logic [CntW-1:0] count_q, count_d;
  logic        full, empty;
  ctrl_t       ctrl;
  logic [2:0]  status_d;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [15:0] tag_q, prio_q;
  logic [6:0]  qcnt_q;
  logic [31:0] cnt_ext;

  entry_t      cell_entry [CAPACITY];
  logic        cell_keep  [CAPACITY];

  assign op             = s_axis_tuser;
  assign new_entry.prio = s_axis_tdata[15:0];
  assign new_entry.tag  = s_axis_tdata[31:16];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign full  = (count_q == CntW'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = ST_CLEARED;
    unique case (op) inside
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          ctrl.ins = in_acc;
          count_d  = count_q + CntW'(1);
        end
      end
      OP_SERVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d = ST_SERVED;
          ctrl.srv = in_acc;
          count_d  = count_q - CntW'(1);
        end
      end
      OP_CLEAR, OP_RSVD: begin
        status_d = ST_CLEARED;
        count_d  = '0;
      end
      default: begin
        status_d = ST_CLEARED;
        count_d  = '0;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   lkeep;
    entry_t lent, rent;
    assign occ = (CntW'(i) < count_q);
    if (i == 0) begin : g_head
      assign lkeep = 1'b1;
      assign lent  = new_entry;
    end else begin : g_body
      assign lkeep = cell_keep[i-1];
      assign lent  = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rent = cell_entry[i];
    end else begin : g_mid
      assign rent = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (occ),
      .new_i      (new_entry),
      .left_keep_i(lkeep),
      .left_i     (lent),
      .right_i    (rent),
      .keep_o     (cell_keep[i]),
      .entry_o    (cell_entry[i])
    );
  end

  assign cnt_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      tag_q    <= (status_d == ST_SERVED) ? cell_entry[0].tag  : 16'd0;
      prio_q   <= (status_d == ST_SERVED) ? cell_entry[0].prio : 16'd0;
      qcnt_q   <= cnt_ext[6:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, qcnt_q, prio_q, tag_q};
  assign m_axis_tuser  = status_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op[1]) |=> (count_q == '0))
    else $error("clear did not empty the queue");

  a_serve_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_SERVE && !empty) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("serve did not remove one entry");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_SERVED) |-> (tag_q == 16'd0 && prio_q == 16'd0))
    else $error("served fields nonzero without a serve");

endmodule
